/* hw/rtl/swre_pkg.sv */
// Shared constants for the sliding window rate estimator.
package swre_pkg;

    // Result field widths
    localparam int BYTE_RATE_W = 32;
    localparam int PKT_RATE_W  = 20;
    localparam int BYTES_W     = 48;
    localparam int PKTS_W      = 32;

    // Fixed-point scaling around the divide: numerator up by 8 bits, quotient up by 2 bits
    localparam int NUM_SHIFT   = 8;
    localparam int QUO_SHIFT   = 2;

endpackage

/* hw/rtl/swre_if.sv */
// Valid/ready channels for packet words in and rate words out.
interface swre_in_if #(
    parameter int LENGTH_BITS = 16,
    parameter int TIME_BITS   = 32
);
    logic                   valid;
    logic                   ready;
    logic [LENGTH_BITS-1:0] packet_length;
    logic [TIME_BITS-1:0]   now_ms;

    modport source (output valid, packet_length, now_ms, input ready);
    modport sink   (input valid, packet_length, now_ms, output ready);
endinterface

interface swre_out_if import swre_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [BYTE_RATE_W-1:0] byte_rate;
    logic [PKT_RATE_W-1:0]  packet_rate;
    logic                   rate_fresh;
    logic [BYTES_W-1:0]     bytes_seen;
    logic [PKTS_W-1:0]      packets_seen;

    modport source (output valid, byte_rate, packet_rate, rate_fresh, bytes_seen,
                    packets_seen, input ready);
    modport sink   (input valid, byte_rate, packet_rate, rate_fresh, bytes_seen,
                    packets_seen, output ready);
endinterface

/* hw/rtl/swre_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module swre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/swre_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module swre_div #(
    parameter int N = 28,
    parameter int D = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [D:0]    trial;
    logic [D:0]    diff;
    logic          fits;
    logic [D-1:0]  rem_next;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[N-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[D-1:0] : trial[D-1:0];
    end

    // Step the quotient one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CW'(N);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[N-2:0], fits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/sliding_window_rate_estimator_core.sv */
// Sliding window packet rate estimator: top level with sequencer and rings.
//
// Usage: each word on pkt carries one packet event (length in bytes and a
// free-running millisecond timestamp). For each word one result word leaves
// on rate: byte and packet rates scaled to about per-second units, a flag
// that says whether they were recomputed, and the running byte and packet
// counters. Rates are computed over the last WINDOW packets.
// Timing: pkt.ready is high only while the sequencer is idle. A word goes
// through a ring read state, an update state and, when time has elapsed
// since the oldest packet in the window, two parallel bit-serial divides of
// LENGTH_BITS + log2(WINDOW) + 8 quotient bits (28 at the defaults). A new
// word is taken only once the last one has left the sequencer for the output
// register, so the divides, when they run, set the throughput.
// Reset clears counters, held rates, ring valid bits and the output stage;
// no clearing pass is needed. A result waits in the output register while
// rate.ready is low; the next word is accepted meanwhile, and its result
// waits in the sequencer until the output register frees.
module sliding_window_rate_estimator_core import swre_pkg::*; #(
    parameter int WINDOW      = 16,
    parameter int LENGTH_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    swre_in_if.sink     pkt,
    swre_out_if.source  rate
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int TOT_W = LENGTH_BITS + IDX_W;
    localparam int DIV_N = TOT_W + NUM_SHIFT;
    localparam int CNT_N = IDX_W + 1 + NUM_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_DIV,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [IDX_W-1:0]       wi_reg;
    logic [IDX_W-1:0]       old_reg;
    logic [IDX_W-1:0]       fill_reg;
    logic                   first_reg;
    logic [WINDOW-1:0]      vld_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [BYTES_W-1:0]     bytes_reg;
    logic [PKTS_W-1:0]      pkts_reg;
    logic [BYTE_RATE_W-1:0] held_br_reg;
    logic [PKT_RATE_W-1:0]  held_pr_reg;
    logic                   fresh_reg;
    logic                   out_valid_reg;
    logic [BYTE_RATE_W-1:0] out_br_reg;
    logic [PKT_RATE_W-1:0]  out_pr_reg;
    logic                   out_fresh_reg;
    logic [BYTES_W-1:0]     out_bytes_reg;
    logic [PKTS_W-1:0]      out_pkts_reg;

    logic                   accept;
    logic                   out_take;
    logic [IDX_W-1:0]       wi_next;
    logic [IDX_W:0]         old_wide;
    logic [IDX_W-1:0]       old_next;
    logic [IDX_W-1:0]       fill_next;
    logic [LENGTH_BITS-1:0] size_rd;
    logic [TIME_BITS-1:0]   time_rd;
    logic [TOT_W-1:0]       total_next;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   div_start;
    logic [DIV_N-1:0]       br_dividend;
    logic [DIV_N-1:0]       pr_dividend;
    logic [CNT_N-1:0]       pr_num;
    logic                   br_done;
    logic                   pr_done;
    logic [DIV_N-1:0]       br_quo;
    logic [DIV_N-1:0]       pr_quo;
    logic [DIV_N+BYTE_RATE_W+QUO_SHIFT-1:0] br_ext;
    logic [DIV_N+PKT_RATE_W+QUO_SHIFT-1:0]  pr_ext;

    assign accept   = pkt.valid && pkt.ready;
    assign out_take = out_valid_reg && rate.ready;

    // Advance the write index and locate the oldest entry in the window
    always_comb
    begin
        wi_next   = (wi_reg == IDX_W'(WINDOW - 1)) ? '0 : wi_reg + 1'b1;
        old_wide  = (wi_next >= fill_reg)
                    ? {1'b0, wi_next} - {1'b0, fill_reg}
                    : {1'b0, wi_next} + (IDX_W + 1)'(WINDOW) - {1'b0, fill_reg};
        old_next  = old_wide[IDX_W-1:0];
        fill_next = (fill_reg == IDX_W'(WINDOW - 1)) ? fill_reg : fill_reg + 1'b1;
    end

    // Rings of sizes and times, read at the new slot and the oldest slot
    swre_ram #(.WIDTH(LENGTH_BITS), .DEPTH(WINDOW)) u_size_ram (
        .clk   (clk),
        .we    (state_reg == S_CALC),
        .waddr (wi_reg),
        .wdata (len_reg),
        .raddr (wi_reg),
        .rdata (size_rd)
    );

    swre_ram #(.WIDTH(TIME_BITS), .DEPTH(WINDOW)) u_time_ram (
        .clk   (clk),
        .we    (state_reg == S_CALC),
        .waddr (wi_reg),
        .wdata (now_reg),
        .raddr (old_reg),
        .rdata (time_rd)
    );

    // Replace the leaving size in the total and measure elapsed time
    always_comb
    begin
        total_next = total_reg
                     - (vld_reg[wi_reg] ? TOT_W'(size_rd) : '0)
                     + TOT_W'(len_reg);
        if (first_reg)
        begin
            elapsed = '0;
        end
        else
        begin
            elapsed = now_reg - (vld_reg[old_reg] ? time_rd : '0);
        end
        pr_num      = {(IDX_W + 1)'(fill_reg) + 1'b1, {NUM_SHIFT{1'b0}}};
        br_dividend = {total_next, {NUM_SHIFT{1'b0}}};
        pr_dividend = DIV_N'(pr_num);
        div_start   = (state_reg == S_CALC) && (elapsed != '0);
    end

    // Two dividers run side by side on the same elapsed time
    swre_div #(.N(DIV_N), .D(TIME_BITS)) u_br_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (br_dividend),
        .divisor  (elapsed),
        .done     (br_done),
        .quotient (br_quo)
    );

    swre_div #(.N(DIV_N), .D(TIME_BITS)) u_pr_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pr_dividend),
        .divisor  (elapsed),
        .done     (pr_done),
        .quotient (pr_quo)
    );

    // Scale quotients up and keep the low bits of each rate field
    assign br_ext = {{BYTE_RATE_W{1'b0}}, br_quo, {QUO_SHIFT{1'b0}}};
    assign pr_ext = {{PKT_RATE_W{1'b0}}, pr_quo, {QUO_SHIFT{1'b0}}};

    // Sequencer, ring state, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            now_reg       <= '0;
            wi_reg        <= '0;
            old_reg       <= '0;
            fill_reg      <= '0;
            first_reg     <= 1'b1;
            vld_reg       <= '0;
            total_reg     <= '0;
            bytes_reg     <= '0;
            pkts_reg      <= '0;
            held_br_reg   <= '0;
            held_pr_reg   <= '0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_br_reg    <= '0;
            out_pr_reg    <= '0;
            out_fresh_reg <= 1'b0;
            out_bytes_reg <= '0;
            out_pkts_reg  <= '0;
        end
        else
        begin
            // Drop the output word once taken, unless the next one replaces it
            if (out_take && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        len_reg   <= pkt.packet_length;
                        now_reg   <= pkt.now_ms;
                        wi_reg    <= wi_next;
                        old_reg   <= old_next;
                        first_reg <= (fill_reg == '0);
                        fill_reg  <= fill_next;
                        bytes_reg <= bytes_reg + BYTES_W'(pkt.packet_length);
                        pkts_reg  <= pkts_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    total_reg       <= total_next;
                    vld_reg[wi_reg] <= 1'b1;
                    fresh_reg       <= div_start;
                    state_reg       <= div_start ? S_DIV : S_DONE;
                end
                S_DIV:
                begin
                    if (br_done && pr_done)
                    begin
                        held_br_reg <= br_ext[BYTE_RATE_W-1:0];
                        held_pr_reg <= pr_ext[PKT_RATE_W-1:0];
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_take)
                    begin
                        out_valid_reg <= 1'b1;
                        out_br_reg    <= held_br_reg;
                        out_pr_reg    <= held_pr_reg;
                        out_fresh_reg <= fresh_reg;
                        out_bytes_reg <= bytes_reg;
                        out_pkts_reg  <= pkts_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pkt.ready         = (state_reg == S_IDLE);
    assign rate.valid        = out_valid_reg;
    assign rate.byte_rate    = out_br_reg;
    assign rate.packet_rate  = out_pr_reg;
    assign rate.rate_fresh   = out_fresh_reg;
    assign rate.bytes_seen   = out_bytes_reg;
    assign rate.packets_seen = out_pkts_reg;

    // A divide starts only on a nonzero elapsed time
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (elapsed != '0))
        else $error("divide started with zero elapsed time");

    // An accepted word moves the sequencer to the ring read
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ))
        else $error("accepted word did not start the ring read");

    // Fill count saturates below the window size
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= IDX_W'(WINDOW - 1))
        else $error("fill count out of range");

    // Both dividers finish together
    a_div_lock: assert property (@(posedge clk) disable iff (!rst_n)
        br_done == pr_done)
        else $error("dividers out of step");

endmodule

/* tb/tb_sliding_window_rate_estimator_core.sv */
// Self-checking testbench for the sliding window rate estimator core.
module tb_sliding_window_rate_estimator_core;
    import swre_pkg::*;

    localparam int WIN       = 16;
    localparam int LEN_W     = 16;
    localparam int TIME_W    = 32;
    localparam int RAND_WORDS = 1430;

    typedef struct packed {
        logic [BYTE_RATE_W-1:0] byte_rate;
        logic [PKT_RATE_W-1:0]  packet_rate;
        logic                   rate_fresh;
        logic [BYTES_W-1:0]     bytes_seen;
        logic [PKTS_W-1:0]      packets_seen;
    } rate_word_t;

    // One row: a run of packets with a fixed length and a fixed time step
    typedef struct {
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now;
        int                reps;
        logic [TIME_W-1:0] step;
        bit                typed;
        rate_word_t        want;
    } stim_row_t;

    stim_row_t plan [7] = '{
        // first packet after reset: oldest entry is itself, held rates are zero
        '{16'hFFFF, 32'd100, 1, 32'd0, 1'b1, '{32'd0, 20'd0, 1'b0, 48'd65535, 32'd1}},
        // same millisecond again: nothing elapsed, rates held
        '{16'h0000, 32'd100, 1, 32'd0, 1'b1, '{32'd0, 20'd0, 1'b0, 48'd65535, 32'd2}},
        '{16'd1000, 32'd101, 1, 32'd0, 1'b0, '0},
        // full-size packets one ms apart: fill the window, wrap the index
        '{16'hFFFF, 32'd102, 16, 32'd1, 1'b0, '0},
        // timestamps across the 32-bit wrap
        '{16'd42, 32'hFFFF_FFFE, 3, 32'd1, 1'b0, '0},
        '{16'h5555, 32'h0000_0003, 1, 32'd0, 1'b0, '0},
        '{16'hAAAA, 32'h8000_0000, 1, 32'd0, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    swre_in_if #(.LENGTH_BITS(LEN_W), .TIME_BITS(TIME_W)) pkt_ch ();
    swre_out_if rate_ch ();

    sliding_window_rate_estimator_core #(
        .WINDOW      (WIN),
        .LENGTH_BITS (LEN_W),
        .TIME_BITS   (TIME_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .rate  (rate_ch)
    );

    // Estimator state mirrored on the testbench side
    logic [LEN_W-1:0]       size_hist [WIN] = '{default: '0};
    logic [TIME_W-1:0]      time_hist [WIN] = '{default: '0};
    logic [3:0]             slot        = '0;
    logic [3:0]             older_cnt   = '0;
    logic [19:0]            win_bytes   = '0;
    logic [BYTES_W-1:0]     byte_total  = '0;
    logic [PKTS_W-1:0]      pkt_total   = '0;
    logic [BYTE_RATE_W-1:0] last_byte_rate = '0;
    logic [PKT_RATE_W-1:0]  last_pkt_rate  = '0;

    rate_word_t expected_rates [$];
    int  err_count  = 0;
    int  words_sent = 0;
    logic hold_off;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Fold one packet into the mirrored state and return its rate word
    function automatic rate_word_t predict_rate(input logic [LEN_W-1:0] len,
                                                input logic [TIME_W-1:0] now);
        rate_word_t    w;
        logic [3:0]    oldest;
        logic [TIME_W-1:0] elapsed;
        w = '0;
        byte_total = byte_total + BYTES_W'(len);
        pkt_total  = pkt_total + 1'b1;
        slot = slot + 1'b1;
        win_bytes = win_bytes - 20'(size_hist[slot]) + 20'(len);
        size_hist[slot] = len;
        time_hist[slot] = now;
        oldest = slot - older_cnt;
        if (older_cnt < WIN - 1)
            older_cnt = older_cnt + 1'b1;
        elapsed = now - time_hist[oldest];
        if (elapsed != '0)
        begin
            last_byte_rate = BYTE_RATE_W'(((64'(win_bytes) << NUM_SHIFT) / 64'(elapsed))
                                          << QUO_SHIFT);
            last_pkt_rate  = PKT_RATE_W'((((64'(older_cnt) + 64'd1) << NUM_SHIFT)
                                          / 64'(elapsed)) << QUO_SHIFT);
            w.rate_fresh = 1'b1;
        end
        w.byte_rate    = last_byte_rate;
        w.packet_rate  = last_pkt_rate;
        w.bytes_seen   = byte_total;
        w.packets_seen = pkt_total;
        return w;
    endfunction

    // Mostly short gaps, some long, none during calm stretches
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(4, 1);
        return $urandom_range(60, 15);
    endfunction

    // Offer one packet word, hold it until accepted, then log its rate word
    task automatic offer_word(input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] now,
                              input int gap, input bit typed, input rate_word_t typed_word);
        rate_word_t predicted;
        if (gap > 0)
        begin
            pkt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt_ch.valid         <= 1'b1;
        pkt_ch.packet_length <= len;
        pkt_ch.now_ms        <= now;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
        predicted = predict_rate(len, now);
        expected_rates.push_back(typed ? typed_word : predicted);
        words_sent++;
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // Stimulus: directed rows, then random traffic
    initial
    begin : drive_words
        int                r;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] clock_ms;
        rate_word_t        none_word;
        none_word = '0;
        clock_ms  = $urandom;
        rst_n = 1'b0;
        pkt_ch.valid         <= 1'b0;
        pkt_ch.packet_length <= '0;
        pkt_ch.now_ms        <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            for (int k = 0; k < plan[i].reps; k++)
                offer_word(plan[i].len, plan[i].now + plan[i].step * k, pick_gap(1'b0),
                           plan[i].typed, plan[i].want);

        for (int n = 0; n < RAND_WORDS; n++)
        begin
            // advance the clock: mostly small steps, some jumps, a few steps back
            r = $urandom_range(99);
            if (r < 30)
                clock_ms = clock_ms;
            else if (r < 70)
                clock_ms = clock_ms + $urandom_range(3, 1);
            else if (r < 85)
                clock_ms = clock_ms + $urandom_range(1000, 4);
            else if (r < 91)
                clock_ms = clock_ms + $urandom;
            else if (r < 95)
                clock_ms = $urandom;
            else if (r < 97)
                clock_ms = {28'hFFF_FFFF, 4'($urandom)};
            else
                clock_ms = clock_ms - $urandom_range(50, 1);

            r = $urandom_range(99);
            if (r < 15)
                len = '0;
            else if (r < 30)
                len = '1;
            else if (r < 60)
                len = LEN_W'($urandom_range(1500, 40));
            else
                len = LEN_W'($urandom);

            offer_word(len, clock_ms, pick_gap((n / 128) % 3 == 1), 1'b0, none_word);
        end
        pkt_ch.valid <= 1'b0;

        while (expected_rates.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("sliding_window_rate_estimator_core regression: pass");
        else
            $display("sliding_window_rate_estimator_core regression: fail");
        $finish;
    end

    // Receiver: random stalls, with calm stretches and one long hold-off
    initial
    begin : drive_ready
        int          stall_left;
        int          r;
        int unsigned cyc;
        stall_left = 0;
        cyc = 0;
        rate_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (stall_left != 0)
            begin
                stall_left--;
                rate_ch.ready <= 1'b0;
            end
            else
            begin
                rate_ch.ready <= !hold_off;
                r = $urandom_range(99);
                if (cyc[10] || r < 55)
                    stall_left = 0;
                else if (r < 90)
                    stall_left = $urandom_range(3, 1);
                else
                    stall_left = $urandom_range(40, 10);
            end
        end
    end

    // Hold the result side off long enough for the input to back up
    initial
    begin
        hold_off <= 1'b0;
        @(posedge clk);
        while (words_sent < 300)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Check each accepted rate word against the oldest pending one
    always @(posedge clk)
    begin : watch_rates
        rate_word_t want;
        if (rst_n && rate_ch.valid && rate_ch.ready)
        begin
            if (expected_rates.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("rate word with nothing pending: byte_rate %h packets_seen %h",
                             rate_ch.byte_rate, rate_ch.packets_seen);
            end
            else
            begin
                want = expected_rates.pop_front();
                if (rate_ch.byte_rate !== want.byte_rate)
                    flag_mismatch("byte_rate", want.byte_rate, rate_ch.byte_rate);
                if (rate_ch.packet_rate !== want.packet_rate)
                    flag_mismatch("packet_rate", want.packet_rate, rate_ch.packet_rate);
                if (rate_ch.rate_fresh !== want.rate_fresh)
                    flag_mismatch("rate_fresh", want.rate_fresh, rate_ch.rate_fresh);
                if (rate_ch.bytes_seen !== want.bytes_seen)
                    flag_mismatch("bytes_seen", want.bytes_seen, rate_ch.bytes_seen);
                if (rate_ch.packets_seen !== want.packets_seen)
                    flag_mismatch("packets_seen", want.packets_seen, rate_ch.packets_seen);
            end
        end
    end

    // Watchdog
    initial
    begin
        #(8 * 1_000_000);
        $display("sliding_window_rate_estimator_core regression: fail");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/swre_pkg.sv
hw/rtl/swre_if.sv
hw/rtl/swre_ram.sv
hw/rtl/swre_div.sv
hw/rtl/sliding_window_rate_estimator_core.sv
tb/tb_sliding_window_rate_estimator_core.sv
